FILE: hdl/rfpf_pkg.sv
// Package for the rangefinder frame parser and forwarder.
// Holds field widths, register indexes, frame byte positions and shared types.
// It depends on nothing else.
package rfpf_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CH_W         = 2;
   localparam int BYTE_W       = 8;
   localparam int DIST_W       = 16;
   localparam int MARKS_W      = 16;
   localparam int MOUNT_W      = 48;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int IDX_W        = 4;

   localparam logic [DIST_W-1:0] DIST_LIMIT_RST = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] REG_INPUT_HEADER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_MIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DISTANCE_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_MARKS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOUNT_ZERO     = 3'd4;

   localparam logic [IDX_W-1:0] FB_START    = 4'd0;
   localparam logic [IDX_W-1:0] FB_CHANNEL  = 4'd1;
   localparam logic [IDX_W-1:0] FB_DIST_LO  = 4'd2;
   localparam logic [IDX_W-1:0] FB_DIST_HI  = 4'd3;
   localparam logic [IDX_W-1:0] FB_ANGLE_LO = 4'd4;
   localparam logic [IDX_W-1:0] FB_ANGLE_HI = 4'd5;
   localparam logic [IDX_W-1:0] FB_X_LO     = 4'd6;
   localparam logic [IDX_W-1:0] FB_X_HI     = 4'd7;
   localparam logic [IDX_W-1:0] FB_Y_LO     = 4'd8;
   localparam logic [IDX_W-1:0] FB_Y_HI     = 4'd9;
   localparam logic [IDX_W-1:0] FB_CHECK    = 4'd10;
   localparam logic [IDX_W-1:0] FB_END      = 4'd11;

   typedef enum logic [1:0] {
      POS_HUNT,
      POS_LOW,
      POS_HIGH,
      POS_CHECK
   } pos_type;

   typedef struct packed {
      pos_type             pos;
      logic [BYTE_W-1:0]   lo;
      logic [BYTE_W-1:0]   hi;
   } parse_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BYTE,
      ST_SEEK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0]    idx;
      logic [CH_W-1:0]     channel;
   } emit_ctl_type;

endpackage

FILE: hdl/rfpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing else.
module rfpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rfpf_framer.sv
// Byte selector for the outgoing 12-byte position frame, including the XOR checksum.
// Depends on rfpf_pkg.
module rfpf_framer import rfpf_pkg::*; (
   input  emit_ctl_type          ctl,
   input  logic [MARKS_W-1:0]    marks,
   input  logic [DIST_W-1:0]     dist_word,
   input  logic [MOUNT_W-1:0]    mount,
   output logic [BYTE_W-1:0]     out_byte
);

   logic [BYTE_W-1:0] chan_byte;
   logic [BYTE_W-1:0] check_byte;

   assign chan_byte  = BYTE_W'(ctl.channel);
   assign check_byte = chan_byte ^ dist_word[7:0] ^ dist_word[15:8] ^ mount[7:0] ^ mount[15:8]
                       ^ mount[23:16] ^ mount[31:24] ^ mount[39:32] ^ mount[47:40];

   always_comb begin
      case (ctl.idx)
         FB_START:    out_byte = marks[7:0];
         FB_CHANNEL:  out_byte = chan_byte;
         FB_DIST_LO:  out_byte = dist_word[7:0];
         FB_DIST_HI:  out_byte = dist_word[15:8];
         FB_ANGLE_LO: out_byte = mount[7:0];
         FB_ANGLE_HI: out_byte = mount[15:8];
         FB_X_LO:     out_byte = mount[23:16];
         FB_X_HI:     out_byte = mount[31:24];
         FB_Y_LO:     out_byte = mount[39:32];
         FB_Y_HI:     out_byte = mount[47:40];
         FB_CHECK:    out_byte = check_byte;
         FB_END:      out_byte = marks[15:8];
         default:     out_byte = '0;
      endcase
   end

endmodule

FILE: hdl/rangefinder_frame_parse_forward.sv
// Top level of the rangefinder frame parser and position-frame forwarder.
// Depends on rfpf_pkg, rfpf_ram and rfpf_framer.
//
// Requests arrive on req_* with valid/ready. A request with req_op low carries a
// received byte for channel req_channel; each channel runs its own frame hunter
// whose state lives in a small RAM. A byte request reads the channel entry when
// it is accepted and writes the entry back in the byte state. Bytes on a channel
// at or above CHANNELS are dropped and the block stays idle.
// A request with req_op high is a forward tick. The block walks the pending
// channels in ascending order and sends a 12-byte position frame for each one on
// rsp_* with valid/ready, with rsp_last_of_run high on the final byte of the tick.
// For each pending channel the tick fetches its distance from RAM in a seek step
// and then sends the frame bytes. A tick with nothing pending stays idle and sends
// nothing. A stalled receiver holds the output register and the walk waits.
// The next request is taken while the last byte still sits in the output register.
// Registers on csr_* are to be written only while the block is idle; the block
// itself does not enforce this, and csr_ready is always high. Reset clears the
// hunters, pending marks and registers, but sets the distance limit to all ones.
module rangefinder_frame_parse_forward import rfpf_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic [CH_W-1:0]         req_channel,
   input  logic [BYTE_W-1:0]       req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_last_of_run,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   state_type              state_ff, state_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [CHANNELS-1:0]    pending_ff, pending_in;
   logic [CHANNELS-1:0]    parse_vld_ff, parse_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [BYTE_W-1:0]      header_ff;
   logic [DIST_W-1:0]      dmin_ff;
   logic [DIST_W-1:0]      dlimit_ff;
   logic [MARKS_W-1:0]     marks_ff;
   logic [MOUNT_W-1:0]     mount_ff [CHANNELS];

   logic                   req_accept;
   logic                   csr_write;
   logic                   in_range;
   logic                   out_free;
   logic                   out_load;
   logic                   seek_found;
   logic [CH_W-1:0]        seek_ch;
   logic                   more;
   logic [ADDR_W-1:0]      ch_addr;

   parse_type              parse_rdata;
   parse_type              parse_cur;
   parse_type              parse_nxt;
   logic                   parse_we;
   logic                   frame_good;
   logic [BYTE_W-1:0]      sum;
   logic [DIST_W-1:0]      cand_dist;
   logic                   dist_we;
   logic                   dist_re;
   logic [DIST_W-1:0]      dist_rdata;
   emit_ctl_type           emit_ctl;
   logic [BYTE_W-1:0]      frame_byte;

   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign in_range   = ({1'b0, req_channel} < (CH_W + 1)'(CHANNELS));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ch_addr    = ch_ff[ADDR_W-1:0];

   always_comb begin
      seek_ch    = '0;
      seek_found = 1'b0;
      more       = 1'b0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (pending_ff[i] && ((CH_W + 1)'(i) >= {1'b0, ch_ff})) begin
            seek_ch    = CH_W'(i);
            seek_found = 1'b1;
         end
         if (pending_ff[i] && ((CH_W + 1)'(i) > {1'b0, ch_ff})) begin
            more = 1'b1;
         end
      end
   end

   rfpf_ram #(
      .WIDTH($bits(parse_type)),
      .DEPTH(CHANNELS)
   ) u_parse_ram (
      .clock   (clock),
      .wr_en   (parse_we),
      .wr_addr (ch_addr),
      .wr_data (parse_nxt),
      .rd_en   (req_accept),
      .rd_addr (req_channel[ADDR_W-1:0]),
      .rd_data (parse_rdata)
   );

   rfpf_ram #(
      .WIDTH(DIST_W),
      .DEPTH(CHANNELS)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (ch_addr),
      .wr_data (cand_dist),
      .rd_en   (dist_re),
      .rd_addr (seek_ch[ADDR_W-1:0]),
      .rd_data (dist_rdata)
   );

   always_comb begin
      parse_cur  = parse_vld_ff[ch_addr] ? parse_rdata : parse_type'('0);
      parse_nxt  = parse_cur;
      frame_good = 1'b0;
      sum        = parse_cur.lo + parse_cur.hi;
      cand_dist  = {parse_cur.hi, parse_cur.lo};
      case (parse_cur.pos)
         POS_HUNT: begin
            if (byte_ff == header_ff) begin
               parse_nxt.pos = POS_LOW;
            end
         end
         POS_LOW: begin
            parse_nxt.lo  = byte_ff;
            parse_nxt.pos = POS_HIGH;
         end
         POS_HIGH: begin
            parse_nxt.hi  = byte_ff;
            parse_nxt.pos = POS_CHECK;
         end
         POS_CHECK: begin
            parse_nxt.pos = POS_HUNT;
            frame_good    = (~sum == byte_ff) && (cand_dist >= dmin_ff)
                            && (cand_dist < dlimit_ff);
         end
         default: begin
            parse_nxt.pos = POS_HUNT;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_op && in_range) begin
                  state_in = ST_BYTE;
               end else if (req_op && (pending_ff != '0)) begin
                  state_in = ST_SEEK;
               end
            end
         end
         ST_BYTE: begin
            state_in = ST_IDLE;
         end
         ST_SEEK: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && (idx_ff == FB_END)) begin
               state_in = more ? ST_SEEK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      parse_we     = (state_ff == ST_BYTE);
      dist_we      = (state_ff == ST_BYTE) && frame_good;
      dist_re      = (state_ff == ST_SEEK);
      out_load     = (state_ff == ST_EMIT) && out_free;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      pending_in   = pending_ff;
      parse_vld_in = parse_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ch_in   = req_op ? '0 : req_channel;
               byte_in = req_rx_byte;
            end
         end
         ST_BYTE: begin
            parse_vld_in[ch_addr] = 1'b1;
            if (frame_good) begin
               pending_in[ch_addr] = 1'b1;
            end
         end
         ST_SEEK: begin
            ch_in  = seek_ch;
            idx_in = FB_START;
            pending_in[seek_ch[ADDR_W-1:0]] = 1'b0;
         end
         ST_EMIT: begin
            if (out_free) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == FB_END) begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: begin
            ch_in = ch_ff;
         end
      endcase
   end

   assign emit_ctl.idx     = idx_ff;
   assign emit_ctl.channel = ch_ff;

   rfpf_framer u_framer (
      .ctl       (emit_ctl),
      .marks     (marks_ff),
      .dist_word (dist_rdata),
      .mount     (mount_ff[ch_addr]),
      .out_byte  (frame_byte)
   );

   always_comb begin
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = frame_byte;
         rsp_last_in  = (idx_ff == FB_END) && !more;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         parse_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
         header_ff    <= '0;
         dmin_ff      <= '0;
         dlimit_ff    <= DIST_LIMIT_RST;
         marks_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         parse_vld_ff <= parse_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               REG_INPUT_HEADER:   header_ff <= csr_data[BYTE_W-1:0];
               REG_DISTANCE_MIN:   dmin_ff   <= csr_data[DIST_W-1:0];
               REG_DISTANCE_LIMIT: dlimit_ff <= csr_data[DIST_W-1:0];
               REG_FRAME_MARKS:    marks_ff  <= csr_data[MARKS_W-1:0];
               default:            header_ff <= header_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (reset) begin
            mount_ff[c] <= '0;
         end else if (csr_write && (csr_index == REG_MOUNT_ZERO + CSR_IDX_W'(c))) begin
            mount_ff[c] <= csr_data[MOUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // A seek step always has a pending channel left to send.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK) |-> seek_found)
      else $error("seek step without a pending channel");

   // The byte that closes a tick ends the walk.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("walk continues after last byte of tick");

   // No pending mark is raised while frames are being sent.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |=> ((pending_ff & ~$past(pending_ff)) == '0))
      else $error("pending mark set during a tick");

   // A tick with nothing pending sends nothing and stays idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op && (pending_ff == '0)) |=> (state_ff == ST_IDLE))
      else $error("empty tick left idle");

endmodule
